FILE: sv/rc4sc_pkg.sv
// shared types and constants for the rc4 stream cipher unit
package rc4sc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DEF_LEN = 8;

  localparam logic [BYTE_W-1:0] LAST_IDX = 8'hFF;

  localparam logic [BYTE_W-1:0] DEFAULT_KEY [DEF_LEN] = '{
    8'h61, 8'h62, 8'h63, 8'h64, 8'h31, 8'h32, 8'h33, 8'h34
  };

  typedef enum logic {
    KIND_KEY  = 1'b0,
    KIND_DATA = 1'b1
  } kind_e;

  typedef struct packed {
    logic latch;      // capture the input byte
    logic key_wr;     // store a key byte
    logic key_last;   // close key entry
    logic sched_init; // clear i, j and key index
    logic fill_wr;    // identity fill, one entry
    logic ks_rd;      // schedule: read perm[i] and key byte
    logic ks_j;       // schedule: update j, read perm[j]
    logic ks_wj;      // schedule: write perm[j]
    logic ks_wi;      // schedule: write perm[i], advance
    logic d_rd;       // read perm[i+1]
    logic d_inc;      // advance i
    logic d_j;        // data: update j, read perm[j]
    logic d_sw;       // data: write perm[i], read perm[t]
    logic d_out;      // data: write perm[j], emit result
  } rc4sc_cmd_t;

  typedef struct packed {
    logic i_last;
    logic out_free;
  } rc4sc_sts_t;

endpackage

FILE: sv/rc4sc_ctrl.sv
// controller state machine for the rc4 stream cipher unit
module rc4sc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_kind_i,
  input  logic               in_last_i,
  output logic               in_stall_o,
  input  rc4sc_pkg::rc4sc_sts_t sts_i,
  output rc4sc_pkg::rc4sc_cmd_t cmd_o
);
  import rc4sc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_FILL = 10'b00_0000_0010,
    S_KRD  = 10'b00_0000_0100,
    S_KJ   = 10'b00_0000_1000,
    S_KWJ  = 10'b00_0001_0000,
    S_KWI  = 10'b00_0010_0000,
    S_DRD  = 10'b00_0100_0000,
    S_DJ   = 10'b00_1000_0000,
    S_DSW  = 10'b01_0000_0000,
    S_DOUT = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   then_data_q, then_data_d;
  logic   acc;
  logic   is_key;

  assign acc        = in_valid_i && (state_q == S_IDLE);
  assign is_key     = (kind_e'(in_kind_i) == KIND_KEY);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    then_data_d = then_data_q;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.d_rd = 1'b1;
        if (acc) begin
          cmd_o.latch = 1'b1;
          if (is_key) begin
            cmd_o.key_wr = 1'b1;
            if (in_last_i) begin
              cmd_o.key_last   = 1'b1;
              cmd_o.sched_init = 1'b1;
              then_data_d      = 1'b0;
              state_d          = S_FILL;
            end
          end else if (pend_q) begin
            cmd_o.sched_init = 1'b1;
            then_data_d      = 1'b1;
            state_d          = S_FILL;
          end else begin
            cmd_o.d_inc = 1'b1;
            state_d     = S_DJ;
          end
        end
      end
      S_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.i_last) state_d = S_KRD;
      end
      S_KRD: begin
        cmd_o.ks_rd = 1'b1;
        state_d     = S_KJ;
      end
      S_KJ: begin
        cmd_o.ks_j = 1'b1;
        state_d    = S_KWJ;
      end
      S_KWJ: begin
        cmd_o.ks_wj = 1'b1;
        state_d     = S_KWI;
      end
      S_KWI: begin
        cmd_o.ks_wi = 1'b1;
        if (sts_i.i_last) begin
          pend_d  = 1'b0;
          state_d = then_data_q ? S_DRD : S_IDLE;
        end else begin
          state_d = S_KRD;
        end
      end
      S_DRD: begin
        cmd_o.d_rd  = 1'b1;
        cmd_o.d_inc = 1'b1;
        state_d     = S_DJ;
      end
      S_DJ: begin
        cmd_o.d_j = 1'b1;
        state_d   = S_DSW;
      end
      S_DSW: begin
        cmd_o.d_sw = 1'b1;
        state_d    = S_DOUT;
      end
      S_DOUT: begin
        cmd_o.d_out = 1'b1;
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b1;
      then_data_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      then_data_q <= then_data_d;
    end
  end

endmodule

FILE: sv/rc4sc_dp.sv
// datapath with permutation and key memories for the rc4 stream cipher unit
module rc4sc_dp #(
  parameter int unsigned MAX_KEY_LEN = 255
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            in_value_i,
  input  rc4sc_pkg::rc4sc_cmd_t cmd_i,
  output rc4sc_pkg::rc4sc_sts_t sts_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [7:0]            out_byte_o
);
  import rc4sc_pkg::*;

  localparam int unsigned KEY_DEPTH = (MAX_KEY_LEN > DEF_LEN) ? MAX_KEY_LEN : DEF_LEN;
  localparam int unsigned KIDX_W    = $clog2(KEY_DEPTH);
  localparam int unsigned KLEN_W    = $clog2(KEY_DEPTH + 1);

  // permutation memory
  logic [BYTE_W-1:0] perm_mem [256];
  logic              pr_en, pw_en;
  logic [BYTE_W-1:0] pr_addr, pw_addr, pw_data, prd_q;

  // key memory
  logic [BYTE_W-1:0] key_mem [KEY_DEPTH];
  logic              kw_en;
  logic [BYTE_W-1:0] krd_q, kdef_byte_q, kbyte;
  logic              kdef_hit_q;
  logic [DEF_LEN-1:0] def_q;

  logic [BYTE_W-1:0] i_q, i_d, j_q, j_d;
  logic [BYTE_W-1:0] si_q, sj_q, t_q, t_d, ks;
  logic [BYTE_W-1:0] value_q, out_q;
  logic              out_valid_q;
  logic [KIDX_W-1:0] kidx_q;
  logic [KLEN_W-1:0] kptr_q, key_len_q, kptr_inc;
  logic              kidx_wrap;

  assign kw_en     = cmd_i.key_wr && (kptr_q < KLEN_W'(MAX_KEY_LEN));
  assign kptr_inc  = kw_en ? KLEN_W'(kptr_q + KLEN_W'(1)) : kptr_q;
  assign kidx_wrap = (KLEN_W'(KLEN_W'(kidx_q) + KLEN_W'(1)) == key_len_q);
  assign kbyte     = kdef_hit_q ? kdef_byte_q : krd_q;
  assign t_d       = BYTE_W'(si_q + prd_q);

  always_comb begin
    pr_en   = cmd_i.d_rd | cmd_i.ks_rd | cmd_i.ks_j | cmd_i.d_j | cmd_i.d_sw;
    pr_addr = BYTE_W'(i_q + 8'd1);
    pw_en   = 1'b0;
    pw_addr = i_q;
    pw_data = prd_q;
    i_d     = i_q;
    j_d     = j_q;
    if (cmd_i.ks_rd) pr_addr = i_q;
    if (cmd_i.ks_j) begin
      j_d     = BYTE_W'(j_q + prd_q + kbyte);
      pr_addr = j_d;
    end
    if (cmd_i.d_j) begin
      j_d     = BYTE_W'(j_q + prd_q);
      pr_addr = j_d;
    end
    if (cmd_i.d_sw) begin
      pr_addr = t_d;
      pw_en   = 1'b1;
    end
    if (cmd_i.fill_wr) begin
      pw_en   = 1'b1;
      pw_data = i_q;
      i_d     = BYTE_W'(i_q + 8'd1);
    end
    if (cmd_i.ks_wj || cmd_i.d_out) begin
      pw_en   = 1'b1;
      pw_addr = j_q;
      pw_data = si_q;
    end
    if (cmd_i.ks_wi) begin
      pw_en = 1'b1;
      i_d   = BYTE_W'(i_q + 8'd1);
      if (i_q == LAST_IDX) j_d = '0;
    end
    if (cmd_i.d_inc) i_d = BYTE_W'(i_q + 8'd1);
    if (cmd_i.sched_init) begin
      i_d = '0;
      j_d = '0;
    end
  end

  // keystream byte, with the swap just made taken into account
  always_comb begin
    if (t_q == j_q) begin
      ks = si_q;
    end else if (t_q == i_q) begin
      ks = sj_q;
    end else begin
      ks = prd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pw_en) perm_mem[pw_addr] <= pw_data;
    if (pr_en) prd_q <= perm_mem[pr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (kw_en) key_mem[kptr_q[KIDX_W-1:0]] <= in_value_i;
    if (cmd_i.ks_rd) begin
      krd_q       <= key_mem[kidx_q];
      kdef_hit_q  <= (KLEN_W'(kidx_q) < KLEN_W'(DEF_LEN)) && def_q[kidx_q[2:0]];
      kdef_byte_q <= DEFAULT_KEY[kidx_q[2:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) value_q <= in_value_i;
    if (cmd_i.ks_j || cmd_i.d_j) si_q <= prd_q;
    if (cmd_i.d_sw) begin
      sj_q <= prd_q;
      t_q  <= t_d;
    end
    if (cmd_i.d_out && sts_o.out_free) out_q <= value_q ^ ks;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      kidx_q      <= '0;
      kptr_q      <= '0;
      key_len_q   <= KLEN_W'(DEF_LEN);
      def_q       <= '1;
      out_valid_q <= 1'b0;
    end else begin
      i_q <= i_d;
      j_q <= j_d;
      if (kw_en && (kptr_q < KLEN_W'(DEF_LEN))) def_q[kptr_q[2:0]] <= 1'b0;
      if (cmd_i.key_last) begin
        key_len_q <= kptr_inc;
        kptr_q    <= '0;
      end else begin
        kptr_q <= kptr_inc;
      end
      if (cmd_i.sched_init) begin
        kidx_q <= '0;
      end else if (cmd_i.ks_wi) begin
        kidx_q <= kidx_wrap ? '0 : KIDX_W'(kidx_q + KIDX_W'(1));
      end
      if (cmd_i.d_out && sts_o.out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.i_last   = (i_q == LAST_IDX);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_q;

endmodule

FILE: sv/rc4_stream_cipher_unit.sv
// top level of the rc4 stream cipher unit
// key beat: a plain one does not stall; the last key beat starts the key schedule
// (identity fill, then a swap step per entry: read, update j, write perm[j], perm[i])
// data beat: j update, swap, then a registered result; the next beat is taken after
// that, and later while the result beat before it is still stalled
// after reset the default key is scheduled when the first data beat arrives
// reset (async, active low) clears control and indexes and restores the default key
// and its length; perm memory is not cleared
module rc4_stream_cipher_unit #(
  parameter int unsigned MAX_KEY_LEN = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       in_kind_i,
  input  logic [7:0] in_value_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o
);
  import rc4sc_pkg::*;

  rc4sc_cmd_t cmd;
  rc4sc_sts_t sts;

  rc4sc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_kind_i),
    .in_last_i  (in_last_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rc4sc_dp #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_value_i  (in_value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o)
  );

endmodule

FILE: sv/rc4sc_checker.sv
// port level checks for the rc4 stream cipher unit
module rc4sc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       in_kind_i,
  input logic [7:0] in_value_i,
  input logic       in_last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o))
    else $error("stalled result beat changed");

  // data beat keeps the unit busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_kind_i |=> in_stall_o)
    else $error("data beat did not occupy the unit");

  // last key beat starts the schedule
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_kind_i && in_last_i |=> in_stall_o)
    else $error("last key beat did not start the schedule");

  // plain key beat does not stall the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_kind_i && !in_last_i |=> !in_stall_o)
    else $error("plain key beat stalled the input");

  // key beats never produce a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_kind_i |=> !$rose(out_valid_o))
    else $error("result appeared after a key beat");

endmodule

bind rc4_stream_cipher_unit rc4sc_checker u_chk (.*);

FILE: verif/tb_top.sv
// testbench for the rc4 stream cipher unit: key and data beats against a keystream predictor
module tb_top;
  import rc4sc_pkg::*;

  localparam int KEY_MAX  = 255;
  localparam int N_BEATS  = 1700;
  localparam int END_WAIT = 1400;

  class rc4_tracker;
    bit [7:0]   perm [256];
    bit [7:0]   key_store [256];
    bit [7:0]   key_len;
    bit [7:0]   wr_ptr;
    bit [7:0]   idx_i;
    bit [7:0]   idx_j;
    bit         sched_due;
    logic [7:0] out_bytes_due [$];
    int         bad;
    int         checked;
    int         schedules;
    int         key_beats;
    int         data_beats;

    function new();
      foreach (key_store[k]) key_store[k] = (k < DEF_LEN) ? DEFAULT_KEY[k] : 8'h00;
      key_len   = DEF_LEN;
      wr_ptr    = 0;
      idx_i     = 0;
      idx_j     = 0;
      sched_due = 1'b1;
    endfunction

    function void schedule_key();
      int       n;
      bit [7:0] j;
      bit [7:0] t;
      n = (key_len == 0) ? 1 : key_len;
      j = 0;
      foreach (perm[k]) perm[k] = 8'(k);
      for (int k = 0; k < 256; k++) begin
        j = j + perm[k] + key_store[k % n];
        t = perm[k];
        perm[k] = perm[j];
        perm[j] = t;
      end
      idx_i     = 0;
      idx_j     = 0;
      sched_due = 1'b0;
      schedules++;
    endfunction

    function void take_beat(kind_e kind, bit [7:0] value, bit last);
      bit [7:0] t;
      if (kind == KIND_KEY) begin
        key_beats++;
        if (wr_ptr < KEY_MAX) begin
          key_store[wr_ptr] = value;
          wr_ptr++;
        end
        if (last) begin
          key_len = (wr_ptr == 0) ? 8'd1 : wr_ptr;
          wr_ptr  = 0;
          schedule_key();
        end
      end else begin
        data_beats++;
        if (sched_due) schedule_key();
        idx_i++;
        idx_j = idx_j + perm[idx_i];
        t = perm[idx_i];
        perm[idx_i] = perm[idx_j];
        perm[idx_j] = t;
        t = perm[idx_i] + perm[idx_j];
        out_bytes_due.push_back(value ^ perm[t]);
      end
    endfunction

    function void check_out_byte(logic [7:0] got);
      logic [7:0] want;
      if (out_bytes_due.size() == 0) begin
        bad++;
        if (bad <= 10) $display("out_byte %02h arrived with nothing outstanding", got);
        return;
      end
      want = out_bytes_due.pop_front();
      checked++;
      if (got !== want) begin
        bad++;
        if (bad <= 10)
          $display("out_byte mismatch on result %0d: expected %02h, got %02h", checked, want, got);
      end
    endfunction
  endclass

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_kind   = 1'b0;
  logic [7:0] in_value  = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;

  rc4_tracker sb = new();
  int         burst_left = 0;
  int         stall_mode = 0;
  int         stall_left = 0;

  rc4_stream_cipher_unit #(
    .MAX_KEY_LEN(KEY_MAX)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_kind_i  (in_kind),
    .in_value_i (in_value),
    .in_last_i  (in_last),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_byte_o (out_byte)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_out_byte(out_byte);
  end

  task automatic send_beat(input kind_e kind, input logic [7:0] value, input logic last);
    bit took;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        in_kind  <= 1'($urandom_range(0, 1));
        in_value <= 8'($urandom_range(0, 255));
        in_last  <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    in_last  <= last;
    do begin
      @(negedge clk_i);
      took = !in_stall;
      if (took) sb.take_beat(kind, value, last);
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic key_run(input int len, input bit close);
    for (int n = 0; n < len; n++)
      send_beat(KIND_KEY, ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
                close && (n == len - 1));
  endtask

  task automatic data_run(input int len);
    for (int n = 0; n < len; n++)
      send_beat(KIND_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int pick;
    int r;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);

    // default key, default key with a partial overwrite, or a fresh one-byte key
    case ($urandom_range(0, 2))
      0: ;
      1: send_beat(KIND_KEY, 8'h00, 1'b0);
      default: send_beat(KIND_KEY, 8'hA5, 1'b1);
    endcase
    send_beat(KIND_DATA, 8'h00, 1'b0);
    send_beat(KIND_DATA, 8'hFF, 1'b1);
    send_beat(KIND_DATA, 8'h5A, 1'b0);
    // zero key byte, then data while the key is half entered
    send_beat(KIND_KEY, 8'h00, 1'b0);
    send_beat(KIND_KEY, 8'hFF, 1'b0);
    send_beat(KIND_DATA, 8'h00, 1'b0);
    send_beat(KIND_DATA, 8'hFF, 1'b0);
    send_beat(KIND_KEY, 8'h80, 1'b1);
    send_beat(KIND_DATA, 8'h00, 1'b1);
    send_beat(KIND_DATA, 8'hFF, 1'b0);
    send_beat(KIND_DATA, 8'h01, 1'b0);
    send_beat(KIND_DATA, 8'h80, 1'b1);
    send_beat(KIND_KEY, 8'hFF, 1'b1);
    send_beat(KIND_DATA, 8'h7F, 1'b0);
    send_beat(KIND_DATA, 8'hFE, 1'b0);
    send_beat(KIND_KEY, 8'h00, 1'b1);
    send_beat(KIND_DATA, 8'h55, 1'b0);
    send_beat(KIND_DATA, 8'hAA, 1'b1);

    // overlong key: bytes past the limit are dropped
    key_run($urandom_range(256, 270), 1'b1);
    data_run($urandom_range(4, 20));

    while (sb.key_beats + sb.data_beats < N_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        r = $urandom_range(0, 9);
        key_run((r < 7) ? $urandom_range(1, 16) :
                (r < 9) ? $urandom_range(17, 64) : $urandom_range(65, 255), 1'b1);
      end else if (pick < 30) begin
        key_run($urandom_range(1, 6), 1'b0);
      end else if (pick < 31) begin
        key_run($urandom_range(250, 262), 1'b1);
      end else begin
        data_run($urandom_range(1, 40));
      end
    end

    in_valid <= 1'b0;
    while (sb.out_bytes_due.size() != 0) @(posedge clk_i);
    repeat (END_WAIT) @(posedge clk_i);

    $display("sent %0d key beats and %0d data beats, %0d key schedules predicted",
             sb.key_beats, sb.data_beats, sb.schedules);
    $display("%0d output bytes compared, %0d failures", sb.checked, sb.bad);
    if (sb.bad == 0 && sb.out_bytes_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("run timed out");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: rc4_stream_cipher_unit.f
sv/rc4sc_pkg.sv
sv/rc4sc_ctrl.sv
sv/rc4sc_dp.sv
sv/rc4_stream_cipher_unit.sv
sv/rc4sc_checker.sv
verif/tb_top.sv
